[hdl/ebrasu_pkg.sv]
// ----------------------------------------------------------------------------
// ebrasu_pkg
// Shared types and constants of the 8-bit register / alu / stack execute unit.
// ----------------------------------------------------------------------------
package ebrasu_pkg;

   // data path width of registers and memory bytes
   localparam int DATA_W = 8;

   // register selects are three bits wide in the request
   localparam int SEL_W     = 3;
   localparam int SEL_COUNT = 2 ** SEL_W;

   // every byte value can address the data memory
   localparam int ADDR_SPACE = 2 ** DATA_W;

   // default configuration
   localparam int NUM_REGS_DEF  = 8;
   localparam int MEM_DEPTH_DEF = 256;
   localparam int STACK_REG_DEF = 7;

   typedef enum logic [3:0] {
      MODE_LDI  = 4'd0,
      MODE_PRN  = 4'd1,
      MODE_PUSH = 4'd2,
      MODE_POP  = 4'd3,
      MODE_MUL  = 4'd4,
      MODE_DIV  = 4'd5,
      MODE_ADD  = 4'd6,
      MODE_SUB  = 4'd7,
      MODE_AND  = 4'd8,
      MODE_INC  = 4'd9,
      MODE_DEC  = 4'd10,
      MODE_XOR  = 4'd11,
      MODE_OR   = 4'd12,
      MODE_MOD  = 4'd13,
      MODE_NOT  = 4'd14
   } mode_type;

   typedef struct packed {
      logic [3:0]        mode;
      logic [SEL_W-1:0]  reg_a;
      logic [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic              print_valid;
      logic [DATA_W-1:0] print_value;
      logic              div_zero_error;
   } rsp_type;

   // divider handshake toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hdl/eight_bit_register_alu_stack_unit.sv]
// ----------------------------------------------------------------------------
// eight_bit_register_alu_stack_unit
// Execute unit of a small 8-bit machine: register file, alu, stack memory.
// ----------------------------------------------------------------------------
//
//   port group   direction   transfer when            carries
//   req_*        in          req_valid & req_ready    mode, reg_a, operand_b
//   rsp_*        out         rsp_valid & rsp_ready    print_valid/value, div_zero_error
//
// each item passes through accept, register read, execute and result; pop adds
// a memory read and, unless it pops into the pointer, a second register write;
// divide and modulo with a nonzero divisor also wait on the eight-step divider.
// reset clears the sequencer, the output valid bit and the valid bits of the
// register file and data memory, so both read as zero until written.
// a result waiting on rsp_ready does not block the next request transfer; the
// sequencer only holds in its result state while the output register is full.
//
module eight_bit_register_alu_stack_unit #(
   parameter int NUM_REGS  = ebrasu_pkg::NUM_REGS_DEF,
   parameter int MEM_DEPTH = ebrasu_pkg::MEM_DEPTH_DEF,
   parameter int STACK_REG = ebrasu_pkg::STACK_REG_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ebrasu_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ebrasu_pkg::rsp_type rsp_data
);

   localparam int D     = ebrasu_pkg::DATA_W;
   localparam int IDX_W = $clog2(NUM_REGS);
   localparam int AW    = $clog2(MEM_DEPTH);
   localparam logic [IDX_W-1:0] SP_IDX = IDX_W'(STACK_REG % NUM_REGS);

   // one-hot sequencer
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_READ   = 8'b0000_0010,
      S_EXEC   = 8'b0000_0100,
      S_POP_A  = 8'b0000_1000,
      S_POP_SP = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_RESULT = 8'b0100_0000,
      S_SPARE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [3:0]       mode_ff, mode_in;
   logic [IDX_W-1:0] a_ff, a_in;
   logic [IDX_W-1:0] b_ff, b_in;
   logic [D-1:0]     imm_ff, imm_in;

   // pending result and output register
   ebrasu_pkg::rsp_type res_ff, res_in;
   ebrasu_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // register index and memory address folding tables
   logic [IDX_W-1:0] reg_map [ebrasu_pkg::SEL_COUNT];
   logic [AW-1:0]    mem_map [ebrasu_pkg::ADDR_SPACE];

   for (genvar g = 0; g < ebrasu_pkg::SEL_COUNT; g++) begin : g_reg_map
      localparam logic [IDX_W-1:0] MAPPED = IDX_W'(g % NUM_REGS);
      assign reg_map[g] = MAPPED;
   end

   for (genvar g = 0; g < ebrasu_pkg::ADDR_SPACE; g++) begin : g_mem_map
      localparam logic [AW-1:0] MAPPED = AW'(g % MEM_DEPTH);
      assign mem_map[g] = MAPPED;
   end

   // register file ports
   logic             rf_rd_en;
   logic [IDX_W-1:0] rf_rd_b_addr;
   logic [D-1:0]     va;
   logic [D-1:0]     vb;
   logic             rf_we;
   logic [IDX_W-1:0] rf_wa;
   logic [D-1:0]     rf_wd;

   // data memory ports
   logic          dm_en;
   logic          dm_we;
   logic [AW-1:0] dm_addr;
   logic [D-1:0]  dm_wd;
   logic [D-1:0]  dm_rd;

   // divider
   logic                       div_start;
   logic [D-1:0]               div_quo;
   logic [D-1:0]               div_rem;
   ebrasu_pkg::div_status_type div_stat;

   // alu
   logic [2*D-1:0] prod;
   logic [D-1:0]   alu_res;
   logic           alu_op;
   logic [D-1:0]   sp_dec;
   logic           stack_is_a;
   logic           out_free;
   logic           is_stack_op;

   assign is_stack_op = (mode_ff == ebrasu_pkg::MODE_PUSH) || (mode_ff == ebrasu_pkg::MODE_POP);
   // on push and pop the second read port fetches the stack pointer
   assign rf_rd_b_addr = is_stack_op ? SP_IDX : b_ff;
   assign rf_rd_en     = (state_ff == S_READ);

   ebrasu_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rf_rd_en),
      .rd_a_addr (a_ff),
      .rd_b_addr (rf_rd_b_addr),
      .rd_a_data (va),
      .rd_b_data (vb),
      .wr_en     (rf_we),
      .wr_addr   (rf_wa),
      .wr_data   (rf_wd)
   );

   ebrasu_datamem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_datamem (
      .clock   (clock),
      .reset   (reset),
      .en      (dm_en),
      .we      (dm_we),
      .addr    (dm_addr),
      .wr_data (dm_wd),
      .rd_data (dm_rd)
   );

   ebrasu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (va),
      .divisor   (vb),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_stat)
   );

   assign prod       = va * vb;
   assign sp_dec     = vb - 1'b1;
   assign stack_is_a = (a_ff == SP_IDX);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // combinational operations writing reg_a
   always_comb begin
      alu_op  = 1'b1;
      alu_res = '0;
      case (mode_ff)
         ebrasu_pkg::MODE_LDI: alu_res = imm_ff;
         ebrasu_pkg::MODE_MUL: alu_res = prod[D-1:0];
         ebrasu_pkg::MODE_ADD: alu_res = va + vb;
         ebrasu_pkg::MODE_SUB: alu_res = va - vb;
         ebrasu_pkg::MODE_AND: alu_res = va & vb;
         ebrasu_pkg::MODE_INC: alu_res = va + 1'b1;
         ebrasu_pkg::MODE_DEC: alu_res = va - 1'b1;
         ebrasu_pkg::MODE_XOR: alu_res = va ^ vb;
         ebrasu_pkg::MODE_OR:  alu_res = va | vb;
         ebrasu_pkg::MODE_NOT: alu_res = ~va;
         default:              alu_op  = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      imm_in    = imm_ff;
      res_in    = res_ff;
      rf_we     = 1'b0;
      rf_wa     = a_ff;
      rf_wd     = alu_res;
      dm_en     = 1'b0;
      dm_we     = 1'b0;
      dm_addr   = mem_map[vb];
      dm_wd     = va;
      div_start = 1'b0;
      req_ready = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_data.mode;
               a_in     = reg_map[req_data.reg_a];
               b_in     = reg_map[req_data.operand_b[ebrasu_pkg::SEL_W-1:0]];
               imm_in   = req_data.operand_b;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in   = '0;
            state_in = S_RESULT;
            if (alu_op) begin
               rf_we = 1'b1;
            end else begin
               case (mode_ff)
                  ebrasu_pkg::MODE_PRN: begin
                     res_in.print_valid = 1'b1;
                     res_in.print_value = va;
                  end
                  ebrasu_pkg::MODE_PUSH: begin
                     // pre-decrement, then store; pushing the pointer stores its new value
                     rf_we   = 1'b1;
                     rf_wa   = SP_IDX;
                     rf_wd   = sp_dec;
                     dm_en   = 1'b1;
                     dm_we   = 1'b1;
                     dm_addr = mem_map[sp_dec];
                     dm_wd   = stack_is_a ? sp_dec : va;
                  end
                  ebrasu_pkg::MODE_POP: begin
                     dm_en    = 1'b1;
                     state_in = S_POP_A;
                  end
                  ebrasu_pkg::MODE_DIV, ebrasu_pkg::MODE_MOD: begin
                     if (vb == '0) begin
                        res_in.div_zero_error = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     // unused opcode: no state change, all-zero result
                  end
               endcase
            end
         end
         S_POP_A: begin
            rf_we = 1'b1;
            if (stack_is_a) begin
               // popping into the pointer: loaded byte, then post-increment
               rf_wa    = SP_IDX;
               rf_wd    = dm_rd + 1'b1;
               state_in = S_RESULT;
            end else begin
               rf_wd    = dm_rd;
               state_in = S_POP_SP;
            end
         end
         S_POP_SP: begin
            rf_we    = 1'b1;
            rf_wa    = SP_IDX;
            rf_wd    = vb + 1'b1;
            state_in = S_RESULT;
         end
         S_DIV: begin
            if (div_stat.done) begin
               rf_we    = 1'b1;
               rf_wd    = (mode_ff == ebrasu_pkg::MODE_MOD) ? div_rem : div_quo;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      imm_ff      <= imm_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a request transfer always starts with the register read
   a_req_to_read: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_READ)
      else $error("request transfer did not start a register read");

   // the divider only finishes while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait state");

   // a new result only appears out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("result appeared without passing the result state");

   // no register write while waiting for a request
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rf_we && !dm_we)
      else $error("state written while idle");

endmodule

[hdl/ebrasu_regfile.sv]
// ----------------------------------------------------------------------------
// ebrasu_regfile
// Register file with two registered read ports, one write port, valid bits.
// ----------------------------------------------------------------------------
module ebrasu_regfile #(
   parameter int NUM_REGS = ebrasu_pkg::NUM_REGS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [$clog2(NUM_REGS)-1:0]         rd_a_addr,
   input  logic [$clog2(NUM_REGS)-1:0]         rd_b_addr,
   output logic [ebrasu_pkg::DATA_W-1:0]       rd_a_data,
   output logic [ebrasu_pkg::DATA_W-1:0]       rd_b_data,
   input  logic                                wr_en,
   input  logic [$clog2(NUM_REGS)-1:0]         wr_addr,
   input  logic [ebrasu_pkg::DATA_W-1:0]       wr_data
);

   localparam int D = ebrasu_pkg::DATA_W;

   logic [D-1:0]        mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic [NUM_REGS-1:0] vld_in;
   logic [D-1:0]        rd_a_ff;
   logic [D-1:0]        rd_b_ff;
   logic                rd_a_vld_ff;
   logic                rd_b_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff     <= mem[rd_a_addr];
         rd_b_ff     <= mem[rd_b_addr];
         rd_a_vld_ff <= vld_ff[rd_a_addr];
         rd_b_vld_ff <= vld_ff[rd_b_addr];
      end
   end

   // never-written entries read as zero
   assign rd_a_data = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_b_data = rd_b_vld_ff ? rd_b_ff : '0;

endmodule

[hdl/ebrasu_datamem.sv]
// ----------------------------------------------------------------------------
// ebrasu_datamem
// Single-port data memory for the stack, registered read, valid bits.
// ----------------------------------------------------------------------------
module ebrasu_datamem #(
   parameter int MEM_DEPTH = ebrasu_pkg::MEM_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            we,
   input  logic [$clog2(MEM_DEPTH)-1:0]    addr,
   input  logic [ebrasu_pkg::DATA_W-1:0]   wr_data,
   output logic [ebrasu_pkg::DATA_W-1:0]   rd_data
);

   localparam int D = ebrasu_pkg::DATA_W;

   logic [D-1:0]         mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [MEM_DEPTH-1:0] vld_in;
   logic [D-1:0]         rd_ff;
   logic                 rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (en && we) begin
         vld_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wr_data;
         end else begin
            rd_ff     <= mem[addr];
            rd_vld_ff <= vld_ff[addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

[hdl/ebrasu_divider.sv]
// ----------------------------------------------------------------------------
// ebrasu_divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module ebrasu_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ebrasu_pkg::DATA_W-1:0]     dividend,
   input  logic [ebrasu_pkg::DATA_W-1:0]     divisor,
   output logic [ebrasu_pkg::DATA_W-1:0]     quotient,
   output logic [ebrasu_pkg::DATA_W-1:0]     remainder,
   output ebrasu_pkg::div_status_type        status
);

   localparam int D   = ebrasu_pkg::DATA_W;
   localparam int CNT_W = $clog2(D);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(D - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D-1:0]     rem_ff, rem_in;
   logic [D-1:0]     quot_ff, quot_in;
   logic [D-1:0]     dsr_ff, dsr_in;
   logic [D:0]       trial;
   logic [D:0]       diff;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quot_ff[D-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (diff[D]) begin
            rem_in  = trial[D-1:0];
            quot_in = {quot_ff[D-2:0], 1'b0};
         end else begin
            rem_in  = diff[D-1:0];
            quot_in = {quot_ff[D-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient    = quot_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[sim/eight_bit_register_alu_stack_unit_tb.sv]
// ----------------------------------------------------------------------------
// eight_bit_register_alu_stack_unit_tb
// Self-checking bench for the 8-bit register / alu / stack execute unit. A
// shadow copy of the register file and data memory predicts every response.
// Directed operations, random short programs, a long output stall and a
// back-to-back stream are applied. Each response is compared field by field.
// ----------------------------------------------------------------------------
module eight_bit_register_alu_stack_unit_tb;

   // the request mode encoding that names no operation
   localparam logic [3:0] MODE_UNUSED = 4'd15;

   // no-transfer cycles before the run is declared hung
   localparam int IDLE_LIMIT = 2000;
   // length of the deliberate output stall
   localparam int HOLD_CYCLES = 300;
   // settle time after the last response
   localparam int TAIL_CYCLES = 40;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   ebrasu_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   ebrasu_pkg::rsp_type rsp_data;

   // shadow state of the unit
   logic [ebrasu_pkg::DATA_W-1:0] reg_mirror [ebrasu_pkg::NUM_REGS_DEF];
   logic [ebrasu_pkg::DATA_W-1:0] mem_mirror [ebrasu_pkg::MEM_DEPTH_DEF];

   // responses predicted but not yet seen, oldest first
   ebrasu_pkg::rsp_type pending_results [$];

   // knobs shared between the test tasks and the receiver
   bit req_gaps   = 1'b1;
   bit rsp_stalls = 1'b1;
   bit hold_rsp   = 1'b0;

   int n_sent      = 0;
   int n_checked   = 0;
   int n_prints    = 0;
   int n_div_zero  = 0;
   int n_errors    = 0;
   int idle_cycles = 0;

   eight_bit_register_alu_stack_unit #(
      .NUM_REGS  (ebrasu_pkg::NUM_REGS_DEF),
      .MEM_DEPTH (ebrasu_pkg::MEM_DEPTH_DEF),
      .STACK_REG (ebrasu_pkg::STACK_REG_DEF)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction: apply one operation to the shadow state, return the response
   // ------------------------------------------------------------------------
   function automatic ebrasu_pkg::rsp_type execute_op(ebrasu_pkg::req_type op);
      ebrasu_pkg::rsp_type           r;
      int unsigned                   a;
      int unsigned                   b;
      int unsigned                   sp;
      logic [ebrasu_pkg::DATA_W-1:0] va;
      logic [ebrasu_pkg::DATA_W-1:0] vb;
      r  = '0;
      // register selects wrap to the register count, the stack register too
      a  = op.reg_a % ebrasu_pkg::NUM_REGS_DEF;
      b  = op.operand_b[ebrasu_pkg::SEL_W-1:0] % ebrasu_pkg::NUM_REGS_DEF;
      sp = ebrasu_pkg::STACK_REG_DEF % ebrasu_pkg::NUM_REGS_DEF;
      va = reg_mirror[a];
      vb = reg_mirror[b];
      case (op.mode)
         ebrasu_pkg::MODE_LDI: reg_mirror[a] = op.operand_b;
         ebrasu_pkg::MODE_PRN: begin
            r.print_valid = 1'b1;
            r.print_value = va;
         end
         // pre-decrement, then store; pushing the stack register stores the
         // already decremented pointer
         ebrasu_pkg::MODE_PUSH: begin
            reg_mirror[sp] = reg_mirror[sp] - 8'd1;
            mem_mirror[reg_mirror[sp] % ebrasu_pkg::MEM_DEPTH_DEF] = reg_mirror[a];
         end
         // load, then post-increment; popping into the stack register gets
         // the loaded byte plus one
         ebrasu_pkg::MODE_POP: begin
            reg_mirror[a]  = mem_mirror[reg_mirror[sp] % ebrasu_pkg::MEM_DEPTH_DEF];
            reg_mirror[sp] = reg_mirror[sp] + 8'd1;
         end
         ebrasu_pkg::MODE_MUL: reg_mirror[a] = va * vb;
         ebrasu_pkg::MODE_DIV: begin
            if (vb != 0) begin
               reg_mirror[a] = va / vb;
            end else begin
               r.div_zero_error = 1'b1;
            end
         end
         ebrasu_pkg::MODE_ADD: reg_mirror[a] = va + vb;
         ebrasu_pkg::MODE_SUB: reg_mirror[a] = va - vb;
         ebrasu_pkg::MODE_AND: reg_mirror[a] = va & vb;
         ebrasu_pkg::MODE_INC: reg_mirror[a] = va + 8'd1;
         ebrasu_pkg::MODE_DEC: reg_mirror[a] = va - 8'd1;
         ebrasu_pkg::MODE_XOR: reg_mirror[a] = va ^ vb;
         ebrasu_pkg::MODE_OR:  reg_mirror[a] = va | vb;
         ebrasu_pkg::MODE_MOD: begin
            if (vb != 0) begin
               reg_mirror[a] = va % vb;
            end else begin
               r.div_zero_error = 1'b1;
            end
         end
         ebrasu_pkg::MODE_NOT: reg_mirror[a] = ~va;
         // the unused mode leaves everything alone and answers all zero
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side: one transfer, with an optional random gap in front of it
   // ------------------------------------------------------------------------
   task automatic send_op(input logic [3:0] mode, input int unsigned ra,
                          input logic [ebrasu_pkg::DATA_W-1:0] ob);
      ebrasu_pkg::req_type op;
      int unsigned         gap;
      op.mode      = mode;
      op.reg_a     = ra[ebrasu_pkg::SEL_W-1:0];
      op.operand_b = ob;
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      // ready is stable between edges, so look at it mid-cycle; the transfer
      // happens at the edge that follows
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      pending_results.push_back(execute_op(op));
      n_sent++;
   endtask

   // stop offering and wait until every predicted response has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [ebrasu_pkg::DATA_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(1, 3));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic ebrasu_pkg::mode_type rand_alu_mode();
      case ($urandom_range(0, 10))
         0:       return ebrasu_pkg::MODE_MUL;
         1:       return ebrasu_pkg::MODE_DIV;
         2:       return ebrasu_pkg::MODE_ADD;
         3:       return ebrasu_pkg::MODE_SUB;
         4:       return ebrasu_pkg::MODE_AND;
         5:       return ebrasu_pkg::MODE_INC;
         6:       return ebrasu_pkg::MODE_DEC;
         7:       return ebrasu_pkg::MODE_XOR;
         8:       return ebrasu_pkg::MODE_OR;
         9:       return ebrasu_pkg::MODE_MOD;
         default: return ebrasu_pkg::MODE_NOT;
      endcase
   endfunction

   // a short program: load, compute, balanced push/pop, print, maybe noise
   task automatic run_program();
      int unsigned n;
      int unsigned k;
      n = $urandom_range(1, 3);
      repeat (n) send_op(ebrasu_pkg::MODE_LDI, $urandom_range(0, 7), rand_byte());
      n = $urandom_range(2, 7);
      repeat (n) send_op(rand_alu_mode(), $urandom_range(0, 7), 8'($urandom_range(0, 255)));
      k = $urandom_range(0, 3);
      repeat (k) begin
         send_op(ebrasu_pkg::MODE_PUSH, $urandom_range(0, 7), 8'($urandom_range(0, 255)));
      end
      repeat (k) begin
         send_op(ebrasu_pkg::MODE_POP, $urandom_range(0, 7), 8'($urandom_range(0, 255)));
      end
      n = $urandom_range(1, 2);
      repeat (n) begin
         send_op(ebrasu_pkg::MODE_PRN, $urandom_range(0, 7), 8'($urandom_range(0, 255)));
      end
      // stray item with any mode, the unused one included
      if ($urandom_range(0, 3) == 0) begin
         send_op(4'($urandom_range(0, 15)), $urandom_range(0, 7),
                 8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------------
   // response side: ready with random stall bursts, plus a long hold on demand
   // ------------------------------------------------------------------------
   initial begin : rsp_driver
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (n_errors < 100) begin
         $display("[%0t] bad %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      end
      n_errors++;
   endtask

   // compare mid-cycle, when valid and ready are settled for the coming edge
   always @(negedge clock) begin : check_results
      ebrasu_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing outstanding", int'(rsp_data), 0);
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (want.print_valid) n_prints++;
            if (want.div_zero_error) n_div_zero++;
            if (rsp_data.print_valid !== want.print_valid) begin
               report_mismatch("print_valid", int'(rsp_data.print_valid),
                               int'(want.print_valid));
            end
            if (rsp_data.print_value !== want.print_value) begin
               report_mismatch("print_value", int'(rsp_data.print_value),
                               int'(want.print_value));
            end
            if (rsp_data.div_zero_error !== want.div_zero_error) begin
               report_mismatch("div_zero_error", int'(rsp_data.div_zero_error),
                               int'(want.div_zero_error));
            end
         end
      end
   end

   // hang detector: counts cycles with no transfer on either channel
   always @(negedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // every operation at least once, field extremes, zero divisors, stack register cases
   task automatic test_directed_ops();
      send_op(ebrasu_pkg::MODE_LDI, 0, 8'd255);
      send_op(ebrasu_pkg::MODE_LDI, 1, 8'd0);
      send_op(ebrasu_pkg::MODE_PRN, 0, 8'h00);
      // upper bits of operand_b are ignored for the register select
      send_op(ebrasu_pkg::MODE_DIV, 0, 8'hF9);          // divide by zero register
      send_op(ebrasu_pkg::MODE_MOD, 0, 8'h01);          // modulo by zero register
      send_op(ebrasu_pkg::MODE_PRN, 0, 8'hFF);          // r0 must still hold 255
      send_op(ebrasu_pkg::MODE_LDI, 2, 8'd7);
      send_op(ebrasu_pkg::MODE_DIV, 0, 8'h02);
      send_op(ebrasu_pkg::MODE_LDI, 3, 8'd200);
      send_op(ebrasu_pkg::MODE_MUL, 3, 8'h0A);          // product wraps
      send_op(ebrasu_pkg::MODE_MOD, 3, 8'h02);
      send_op(ebrasu_pkg::MODE_ADD, 3, 8'h00);
      send_op(ebrasu_pkg::MODE_SUB, 1, 8'h00);          // 0 - r0 wraps
      send_op(ebrasu_pkg::MODE_AND, 0, 8'h03);
      send_op(ebrasu_pkg::MODE_XOR, 2, 8'h03);
      send_op(ebrasu_pkg::MODE_OR,  2, 8'h00);
      send_op(ebrasu_pkg::MODE_INC, 0, 8'h00);
      send_op(ebrasu_pkg::MODE_DEC, 4, 8'h00);          // 0 - 1 wraps to 255
      send_op(ebrasu_pkg::MODE_NOT, 2, 8'h00);
      send_op(ebrasu_pkg::MODE_PUSH, 7, 8'h00);         // push of the stack pointer itself
      send_op(ebrasu_pkg::MODE_POP, 7, 8'h00);          // pop into the stack pointer
      send_op(ebrasu_pkg::MODE_PUSH, 2, 8'h00);
      send_op(ebrasu_pkg::MODE_POP, 5, 8'h00);
      send_op(MODE_UNUSED, 7, 8'hFF);
      send_op(ebrasu_pkg::MODE_PRN, 5, 8'h00);
      send_op(ebrasu_pkg::MODE_PRN, 7, 8'h00);
      drain();
   endtask

   task automatic test_random_programs(input int count);
      int stop_at;
      stop_at = n_sent + count;
      while (n_sent < stop_at) run_program();
      drain();
   endtask

   // the receiver stalls for a long stretch while requests keep coming, so
   // the unit fills up and has to hold off its input
   task automatic test_output_backpressure();
      req_gaps = 1'b0;
      hold_rsp = 1'b1;
      repeat (24) begin
         send_op(rand_alu_mode(), $urandom_range(0, 7), 8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;
      while (hold_rsp) @(posedge clock);
      drain();
      req_gaps = 1'b1;
   endtask

   // full rate on both sides, no idling at all
   task automatic test_back_to_back(input int count);
      int stop_at;
      req_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      stop_at    = n_sent + count;
      while (n_sent < stop_at) run_program();
      drain();
   endtask

   initial begin : main
      foreach (reg_mirror[i]) reg_mirror[i] = '0;
      foreach (mem_mirror[i]) mem_mirror[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_random_programs(430);
      test_output_backpressure();
      test_back_to_back(120);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d operations, %0d responses checked", n_sent, n_checked);
      $display("including %0d prints and %0d refused divides or modulos",
               n_prints, n_div_zero);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
